### design/sorted_datetime_table_defines.svh
// Assertion macros used by the sorted date/time table controller.
`ifndef SORTED_DATETIME_TABLE_DEFINES_SVH
`define SORTED_DATETIME_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SDT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SDT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/sdt_pkg.sv
// Types, constants and helpers of the sorted date/time table.
package sdt_pkg;

	localparam int CAPACITY = 32;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 20;
	localparam int ENTRY_W  = 36;

	// Input range limits
	localparam logic signed [7:0] MONTH_MIN  = 8'sd1;
	localparam logic signed [7:0] MONTH_MAX  = 8'sd12;
	localparam logic signed [7:0] DAY_MIN    = 8'sd1;
	localparam logic signed [7:0] DAY_MAX    = 8'sd31;
	localparam logic signed [7:0] HOUR_MAX   = 8'sd23;
	localparam logic signed [7:0] MINUTE_MAX = 8'sd59;

	typedef enum logic [2:0] {
		ST_STORED   = 3'd0,
		ST_BAD_DATE = 3'd1,
		ST_BAD_TIME = 3'd2,
		ST_LISTED   = 3'd3,
		ST_FULL     = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef struct packed {
		logic signed [7:0] month;
		logic signed [7:0] day;
		logic signed [7:0] hour;
		logic signed [7:0] minute;
		logic [15:0]       message_tag;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [4:0]  out_hour;
		logic [5:0]  out_minute;
		logic [15:0] out_tag;
		logic        last;
	} result_t;

	// Stored entry; the low 20 bits form the ordering key
	typedef struct packed {
		logic [15:0] tag;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} entry_t;

	typedef logic [KEY_W-1:0] key_t;

	// Write and read request to the entry memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic key_t key_of(entry_t e);
		return {e.month, e.day, e.hour, e.minute};
	endfunction

endpackage

### design/sdt_ram.sv
// Generic simple dual-port RAM with registered read data.
module sdt_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/sdt_outreg.sv
// Result register between the controller and the result channel.
module sdt_outreg import sdt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    ld_valid,
	input  result_t ld_data,
	output logic    can_load,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic    valid_q;
	result_t data_q;

	// Slot is free when empty or being drained this cycle
	assign can_load     = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld_valid) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_valid) begin
			data_q <= ld_data;
		end
	end

endmodule

### design/sdt_ctrl.sv
// Sequencer: decode, insertion scan over the entry memory, listing.
module sdt_ctrl import sdt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  item_t    item,
	input  logic     can_load,
	output logic     ld_valid,
	output result_t  ld_data,
	output mem_req_t mem,
	input  entry_t   rdata
);

`include "sorted_datetime_table_defines.svh"

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_PUT    = 7'b0001000,
		S_STORED = 7'b0010000,
		S_FULL   = 7'b0100000,
		S_LIST   = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	item_t             item_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic              rd_more_q;
	logic              vld_s1;
	logic [ADDR_W-1:0] addr_s1;

	entry_t new_e;
	key_t   new_key;
	logic   is_end, bad_date, bad_time, cnt_full, cnt_zero;
	logic   scan_go, scan_stop, idx_last;

	assign item_ready = (state_q == S_IDLE);

	// Item classification
	always_comb begin
		new_e.tag    = item_q.message_tag;
		new_e.month  = item_q.month[3:0];
		new_e.day    = item_q.day[4:0];
		new_e.hour   = item_q.hour[4:0];
		new_e.minute = item_q.minute[5:0];
		new_key      = key_of(new_e);
		is_end   = (item_q.month == 8'sd0) || (item_q.day == 8'sd0);
		bad_date = (item_q.month < MONTH_MIN) || (item_q.month > MONTH_MAX) ||
			(item_q.day < DAY_MIN) || (item_q.day > DAY_MAX);
		bad_time = (item_q.hour < 8'sd0) || (item_q.hour > HOUR_MAX) ||
			(item_q.minute < 8'sd0) || (item_q.minute > MINUTE_MAX);
		cnt_full = (cnt_q >= CNT_W'(CAPACITY));
		cnt_zero = (cnt_q == '0);
		// Stored entry with a larger key moves up one slot
		scan_go   = vld_s1 && (key_of(rdata) > new_key);
		scan_stop = vld_s1 && !(key_of(rdata) > new_key);
		idx_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
	end

	// Next state, memory requests, result loads
	always_comb begin
		state_d  = state_q;
		mem      = '0;
		ld_valid = 1'b0;
		ld_data  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (is_end) begin
					if (cnt_zero) begin
						if (can_load) begin
							ld_valid       = 1'b1;
							ld_data.status = ST_EMPTY;
							ld_data.last   = 1'b1;
							state_d        = S_IDLE;
						end
					end else begin
						mem.re    = 1'b1;
						mem.raddr = '0;
						state_d   = S_LIST;
					end
				end else if (bad_date || bad_time) begin
					if (can_load) begin
						ld_valid       = 1'b1;
						ld_data.status = bad_date ? ST_BAD_DATE : ST_BAD_TIME;
						ld_data.last   = 1'b1;
						state_d        = S_IDLE;
					end
				end else if (cnt_full) begin
					state_d = S_FULL;
				end else if (cnt_zero) begin
					state_d = S_PUT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				mem.re    = rd_more_q;
				mem.raddr = rd_ptr_q;
				if (scan_go) begin
					mem.we    = 1'b1;
					mem.waddr = addr_s1 + ADDR_W'(1);
					mem.wdata = rdata;
					if (addr_s1 == '0) begin
						state_d = S_PUT;
					end
				end else if (scan_stop) begin
					mem.we    = 1'b1;
					mem.waddr = addr_s1 + ADDR_W'(1);
					mem.wdata = new_e;
					state_d   = S_STORED;
				end
			end
			S_PUT: begin
				mem.we    = 1'b1;
				mem.waddr = '0;
				mem.wdata = new_e;
				state_d   = S_STORED;
			end
			S_STORED: begin
				if (can_load) begin
					ld_valid       = 1'b1;
					ld_data.status = ST_STORED;
					ld_data.last   = !cnt_full;
					state_d        = cnt_full ? S_FULL : S_IDLE;
				end
			end
			S_FULL: begin
				if (can_load) begin
					ld_valid       = 1'b1;
					ld_data.status = ST_FULL;
					mem.re         = 1'b1;
					mem.raddr      = '0;
					state_d        = S_LIST;
				end
			end
			S_LIST: begin
				if (can_load) begin
					ld_valid           = 1'b1;
					ld_data.status     = ST_LISTED;
					ld_data.out_month  = rdata.month;
					ld_data.out_day    = rdata.day;
					ld_data.out_hour   = rdata.hour;
					ld_data.out_minute = rdata.minute;
					ld_data.out_tag    = rdata.tag;
					ld_data.last       = idx_last;
					if (idx_last) begin
						state_d = S_IDLE;
					end else begin
						mem.re    = 1'b1;
						mem.raddr = idx_q + ADDR_W'(1);
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			rd_ptr_q  <= '0;
			rd_more_q <= 1'b0;
			vld_s1    <= 1'b0;
			addr_s1   <= '0;
		end else begin
			state_q <= state_d;

			// Entry count
			if ((state_q == S_PUT) || ((state_q == S_SCAN) && scan_stop)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if ((state_q == S_LIST) && can_load && idx_last) begin
				cnt_q <= '0;
			end

			// Listing index
			if ((state_d == S_LIST) && (state_q != S_LIST)) begin
				idx_q <= '0;
			end else if ((state_q == S_LIST) && can_load) begin
				idx_q <= idx_q + ADDR_W'(1);
			end

			// Scan read pointer walks down from the top entry
			if (state_q == S_DECODE) begin
				rd_ptr_q  <= ADDR_W'(cnt_q - CNT_W'(1));
				rd_more_q <= 1'b1;
			end else if ((state_q == S_SCAN) && rd_more_q) begin
				if (rd_ptr_q == '0) begin
					rd_more_q <= 1'b0;
				end else begin
					rd_ptr_q <= rd_ptr_q - ADDR_W'(1);
				end
			end

			// Read data stage tag
			vld_s1  <= (state_q == S_SCAN) && rd_more_q && (state_d == S_SCAN);
			addr_s1 <= rd_ptr_q;
		end
	end

	// Captured item
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
	end

	`SDT_ASSERT_NOW(a_rw_apart, mem.we && mem.re, mem.waddr != mem.raddr, "read and write hit same entry")
	`SDT_ASSERT_NOW(a_list_nonempty, state_q == S_LIST, cnt_q != '0, "listing an empty table")
	`SDT_ASSERT_NOW(a_load_free, ld_valid, can_load, "result loaded into a busy register")
	`SDT_ASSERT_NEXT(a_put_counts, state_q == S_PUT, cnt_q == $past(cnt_q) + CNT_W'(1), "insert not counted")

endmodule

### design/sorted_datetime_table.sv
// Top level of the sorted date/time table.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-----------------
//   item     | item_valid / item_ready     | item   (item_t)
//   result   | result_valid / result_ready | result (result_t)
//
// An insert scans the entries from the top down, reading one entry per cycle and
// writing it one slot higher until the insertion point is found.
// A listing gives one entry per cycle while result_ready stays high.
// A bad date or time, or an end marker on an empty table, gives one result.
// Reset clears the count and all control state; the memory needs no clearing.
// A stall on the result side holds the sequencer in the states that load results.
module sorted_datetime_table import sdt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	mem_req_t mem;
	entry_t   rdata;
	logic     can_load;
	logic     ld_valid;
	result_t  ld_data;
	logic [ENTRY_W-1:0] rdata_raw;

	assign rdata = entry_t'(rdata_raw);

	sdt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.can_load   (can_load),
		.ld_valid   (ld_valid),
		.ld_data    (ld_data),
		.mem        (mem),
		.rdata      (rdata)
	);

	sdt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rdata_raw)
	);

	sdt_outreg u_outreg (
		.clk          (clk),
		.arst_n       (arst_n),
		.ld_valid     (ld_valid),
		.ld_data      (ld_data),
		.can_load     (can_load),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

### test/datetime_order_check.sv
// Checker for the sorted date/time table: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module datetime_order_check import sdt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result,
	output int      errors,
	output int      pending
);

	// Shadow copy of the sorted table
	entry_t      slots [CAPACITY];
	int unsigned fill_count;
	result_t     expected_q [$];

	// Ordering key is the low 20 bits: month, day, hour, minute
	function automatic logic [19:0] order_key(entry_t e);
		return e[19:0];
	endfunction

	function automatic result_t make_result(status_t st, entry_t e, logic fin);
		result_t r;
		r.status     = st;
		r.out_month  = e.month;
		r.out_day    = e.day;
		r.out_hour   = e.hour;
		r.out_minute = e.minute;
		r.out_tag    = e.tag;
		r.last       = fin;
		return r;
	endfunction

	// Dump every stored entry in order, then empty the table
	task automatic list_and_clear();
		if (fill_count == 0) begin
			expected_q.push_back(make_result(ST_EMPTY, '0, 1'b1));
		end else begin
			for (int i = 0; i < fill_count; i++)
				expected_q.push_back(make_result(ST_LISTED, slots[i],
					i + 1 == fill_count));
		end
		fill_count = 0;
	endtask

	task automatic predict(item_t it);
		entry_t      e;
		int unsigned pos;
		if (it.month == 0 || it.day == 0) begin
			list_and_clear();
			return;
		end
		if (it.month < MONTH_MIN || it.month > MONTH_MAX ||
				it.day < DAY_MIN || it.day > DAY_MAX) begin
			expected_q.push_back(make_result(ST_BAD_DATE, '0, 1'b1));
			return;
		end
		if (it.hour < 0 || it.hour > HOUR_MAX ||
				it.minute < 0 || it.minute > MINUTE_MAX) begin
			expected_q.push_back(make_result(ST_BAD_TIME, '0, 1'b1));
			return;
		end
		// full table found before insert: flush without storing
		if (fill_count >= CAPACITY) begin
			expected_q.push_back(make_result(ST_FULL, '0, 1'b0));
			list_and_clear();
			return;
		end
		e.tag    = it.message_tag;
		e.month  = it.month[3:0];
		e.day    = it.day[4:0];
		e.hour   = it.hour[4:0];
		e.minute = it.minute[5:0];
		// equal keys: new entry goes after the existing ones
		pos = 0;
		while (pos < fill_count && order_key(slots[pos]) <= order_key(e))
			pos++;
		for (int j = fill_count; j > pos; j--)
			slots[j] = slots[j - 1];
		slots[pos] = e;
		fill_count++;
		if (fill_count >= CAPACITY) begin
			expected_q.push_back(make_result(ST_STORED, '0, 1'b0));
			expected_q.push_back(make_result(ST_FULL, '0, 1'b0));
			list_and_clear();
		end else begin
			expected_q.push_back(make_result(ST_STORED, '0, 1'b1));
		end
	endtask

	// Results first: nothing accepted at this edge can cause one at the same edge
	always @(posedge clk) begin
		result_t exp;
		if (!arst_n) begin
			fill_count = 0;
			expected_q.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected st=%0d mo=%0d dy=%0d hr=%0d mi=%0d tag=%h last=%0b",
						$time, result.status, result.out_month, result.out_day,
						result.out_hour, result.out_minute, result.out_tag, result.last);
				end else begin
					exp = expected_q.pop_front();
					if (result !== exp) begin
						errors++;
						$display("%0t: expected st=%0d mo=%0d dy=%0d hr=%0d mi=%0d tag=%h last=%0b",
							$time, exp.status, exp.out_month, exp.out_day,
							exp.out_hour, exp.out_minute, exp.out_tag, exp.last);
						$display("%0t: actual   st=%0d mo=%0d dy=%0d hr=%0d mi=%0d tag=%h last=%0b",
							$time, result.status, result.out_month, result.out_day,
							result.out_hour, result.out_minute, result.out_tag, result.last);
					end
				end
			end
			if (item_valid && item_ready)
				predict(item);
		end
		pending = expected_q.size();
	end

endmodule

### test/tb_sorted_datetime_table.sv
// Testbench top for the sorted date/time table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_sorted_datetime_table;
	import sdt_pkg::*;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;
	int      errors;
	int      pending;
	int      items_sent;
	bit      quiet;

	sorted_datetime_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	datetime_order_check order_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, a few long ones; none during quiet stretches
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic item_t mk(int mo, int dy, int hr, int mi, int tag);
		item_t x;
		x.month       = 8'(mo);
		x.day         = 8'(dy);
		x.hour        = 8'(hr);
		x.minute      = 8'(mi);
		x.message_tag = 16'(tag);
		return x;
	endfunction

	// Mostly -9 to 99, sometimes any byte
	function automatic int rand_byte();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 255);
		return int'($urandom_range(0, 108)) - 9;
	endfunction

	function automatic item_t good_entry(bit narrow);
		return mk(narrow ? $urandom_range(1, 2) : $urandom_range(1, 12),
			narrow ? $urandom_range(1, 2) : $urandom_range(1, 31),
			narrow ? $urandom_range(0, 1) : $urandom_range(0, 23),
			narrow ? $urandom_range(0, 1) : $urandom_range(0, 59),
			$urandom_range(0, 65535));
	endfunction

	function automatic item_t end_marker();
		int kind;
		kind = $urandom_range(0, 2);
		return mk(kind == 1 ? rand_byte() : 0, kind == 0 ? rand_byte() : 0,
			rand_byte(), rand_byte(), $urandom_range(0, 65535));
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(item_t x);
		int g;
		g = pause_len();
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		item       <= x;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Receiver back-pressure
	initial begin
		int stall;
		stall = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				result_ready <= 1'b1;
			end else if (stall > 0) begin
				result_ready <= 1'b0;
				stall--;
			end else begin
				result_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
						: $urandom_range(1, 3);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int  len;
		bit  narrow;
		item_valid = 1'b0;
		item       = '0;
		items_sent = 0;
		quiet      = 1'b0;
		arst_n     = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty listing, bad dates, bad times, extremes, ties
		send_item(mk(0, 5, 3, 4, 16'h0001));
		send_item(mk(13, 1, 0, 0, 16'h0002));
		send_item(mk(-9, 31, 0, 0, 16'h0003));
		send_item(mk(1, 32, 0, 0, 16'h0004));
		send_item(mk(12, -1, 0, 0, 16'h0005));
		send_item(mk(99, 99, 99, 99, 16'h0006));
		send_item(mk(1, 1, 24, 0, 16'h0007));
		send_item(mk(1, 1, -9, 0, 16'h0008));
		send_item(mk(1, 1, 0, 60, 16'h0009));
		send_item(mk(1, 1, 23, -1, 16'h000a));
		send_item(mk(12, 31, 23, 59, 16'hffff));
		send_item(mk(1, 1, 0, 0, 16'h0000));
		send_item(mk(6, 15, 12, 30, 16'h1111));
		send_item(mk(6, 15, 12, 30, 16'h2222));
		send_item(mk(6, 15, 12, 30, 16'h3333));
		send_item(mk(6, 15, 12, 29, 16'haaaa));
		send_item(mk(6, 15, 12, 31, 16'h5555));
		// day zero wins over a bad month
		send_item(mk(13, 0, 99, -9, 16'h0bad));
		send_item(mk(0, 0, 0, 0, 16'h0000));
		send_item(mk(-9, 0, 0, 0, 16'h00ff));
		drain_results();

		// Random: sequences of inserts closed by an end marker, some filling the table
		while (items_sent < 270) begin
			quiet  = ($urandom_range(0, 4) == 0);
			narrow = $urandom_range(0, 1);
			len    = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 34)
				: $urandom_range(0, 12);
			for (int i = 0; i < len; i++) begin
				if (len <= 12 && $urandom_range(0, 6) == 0)
					send_item(mk(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
						$urandom_range(0, 65535)));
				else
					send_item(good_entry(narrow));
			end
			if ($urandom_range(0, 7) == 0)
				drain_results();
			send_item(end_marker());
		end
		quiet = 1'b0;
		drain_results();
		repeat (50) @(negedge clk);

		if (errors == 0)
			$display("PASS sorted_datetime_table");
		else
			$display("FAIL sorted_datetime_table");
		$finish;
	end

	// Watchdog
	initial begin
		#10000000;
		$display("FAIL sorted_datetime_table");
		$finish;
	end

endmodule

### sorted_datetime_table.f
+incdir+design
design/sdt_pkg.sv
design/sdt_ram.sv
design/sdt_outreg.sv
design/sdt_ctrl.sv
design/sorted_datetime_table.sv
test/datetime_order_check.sv
test/tb_sorted_datetime_table.sv
